@@ rtl/calu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_pkg
// Types and operation codes shared by the accumulator ALU and its top level.
// ----------------------------------------------------------------------------
package calu_pkg;

  localparam int unsigned CmdW  = 5;
  localparam int unsigned WordW = 16;
  localparam int unsigned FlagW = 4;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 5'd0,
    CMD_ADC   = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_SBC   = 5'd3,
    CMD_AND   = 5'd4,
    CMD_XOR   = 5'd5,
    CMD_OR    = 5'd6,
    CMD_CP    = 5'd7,
    CMD_INC   = 5'd8,
    CMD_DEC   = 5'd9,
    CMD_RLCA  = 5'd10,
    CMD_RLA   = 5'd11,
    CMD_RRCA  = 5'd12,
    CMD_RRA   = 5'd13,
    CMD_ADD16 = 5'd14,
    CMD_SPE8  = 5'd15,
    CMD_INC16 = 5'd16,
    CMD_DEC16 = 5'd17
  } cmd_e;

  typedef struct packed {
    logic [FlagW-1:0] flags_in;
    logic [WordW-1:0] operand_b;
    logic [WordW-1:0] operand_a;
    logic [CmdW-1:0]  command;
  } calu_item_t;

  typedef struct packed {
    logic [FlagW-1:0] flags_out;
    logic [WordW-1:0] result;
  } calu_res_t;

endpackage

@@ rtl/calu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calu_core
// Combinational 8/16-bit ALU with Z, N, H and C flag generation.
// ----------------------------------------------------------------------------
module calu_core
  import calu_pkg::*;
(
  input  calu_item_t item,
  output calu_res_t  res
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        fc;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  diff9;
  logic [4:0]  hdiff5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] ext16;
  logic [7:0]  r8;

  always_comb begin
    a8  = item.operand_a[7:0];
    b8  = item.operand_b[7:0];
    fc  = item.flags_in[FlagC];
    cin = ((item.command == CMD_ADC) || (item.command == CMD_SBC)) ? fc : 1'b0;

    sum9   = {1'b0, a8} + {1'b0, b8} + {8'b0, cin};
    hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, cin};
    diff9  = {1'b0, a8} - {1'b0, b8} - {8'b0, cin};
    hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'b0, cin};
    inc8   = a8 + 8'd1;
    dec8   = a8 - 8'd1;
    sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    sum13  = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
    ext16  = {{8{b8[7]}}, b8};
    r8     = 8'd0;

    res.result    = item.operand_a;
    res.flags_out = item.flags_in;

    unique case (cmd_e'(item.command))
      CMD_ADD, CMD_ADC: begin
        r8 = sum9[7:0];
        res.result    = {8'd0, r8};
        res.flags_out = {(r8 == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      CMD_SUB, CMD_SBC: begin
        res.result    = {8'd0, diff9[7:0]};
        res.flags_out = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      CMD_CP: begin
        res.flags_out = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      CMD_AND: begin
        r8 = a8 & b8;
        res.result    = {8'd0, r8};
        res.flags_out = {(r8 == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      CMD_XOR: begin
        r8 = a8 ^ b8;
        res.result    = {8'd0, r8};
        res.flags_out = {(r8 == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      CMD_OR: begin
        r8 = a8 | b8;
        res.result    = {8'd0, r8};
        res.flags_out = {(r8 == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      CMD_INC: begin
        res.result    = {8'd0, inc8};
        res.flags_out = {(inc8 == 8'd0), 1'b0, (a8[3:0] == 4'hF), fc};
      end
      CMD_DEC: begin
        res.result    = {8'd0, dec8};
        res.flags_out = {(dec8 == 8'd0), 1'b1, (a8[3:0] == 4'h0), fc};
      end
      CMD_RLCA: begin
        res.result    = {8'd0, a8[6:0], a8[7]};
        res.flags_out = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      CMD_RLA: begin
        res.result    = {8'd0, a8[6:0], fc};
        res.flags_out = {1'b0, 1'b0, 1'b0, a8[7]};
      end
      CMD_RRCA: begin
        res.result    = {8'd0, a8[0], a8[7:1]};
        res.flags_out = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      CMD_RRA: begin
        res.result    = {8'd0, fc, a8[7:1]};
        res.flags_out = {1'b0, 1'b0, 1'b0, a8[0]};
      end
      CMD_ADD16: begin
        res.result    = sum17[15:0];
        res.flags_out = {item.flags_in[FlagZ], 1'b0, sum13[12], sum17[16]};
      end
      CMD_SPE8: begin
        res.result    = item.operand_a + ext16;
        res.flags_out = {1'b0, 1'b0, hsum5[4], sum9[8]};
      end
      CMD_INC16: begin
        res.result = item.operand_a + 16'd1;
      end
      CMD_DEC16: begin
        res.result = item.operand_a - 16'd1;
      end
      default: begin
        res.result    = item.operand_a;
        res.flags_out = item.flags_in;
      end
    endcase
  end

endmodule

@@ rtl/cpu_alu_with_flags.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// Streaming 8/16-bit accumulator ALU with Z, N, H and C flags.
// ----------------------------------------------------------------------------
// Each item carries a command, two operands and the incoming flags and yields
// one item with the result and new flags. Items are captured in an input
// register, pass through the ALU logic and land in an output register. One
// item is taken per cycle while the input register is free; both registers
// advance together whenever the output side is free, so a stalled output
// holds its result and blocks input only when the input register is full.
module cpu_alu_with_flags
  import calu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // command[4:0], operand_a[20:5], operand_b[36:21], flags_in[40:37], zero fill
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // result[15:0], flags_out[19:16], zero fill
  output logic [OutDataW-1:0] m_tdata
);

  logic       pipe_valid;
  calu_item_t pipe_item;
  calu_res_t  alu_res;
  calu_res_t  out_res;
  logic       out_free;
  logic       pipe_free;

  assign out_free  = !m_tvalid || m_tready;
  assign pipe_free = !pipe_valid || out_free;
  assign s_tready  = pipe_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (pipe_free) begin
      pipe_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && pipe_free) begin
      pipe_item <= calu_item_t'(s_tdata[$bits(calu_item_t)-1:0]);
    end
  end

  calu_core u_core (
    .item (pipe_item),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid && out_free) begin
      out_res <= alu_res;
    end
  end

  assign m_tdata = {{(OutDataW-$bits(calu_res_t)){1'b0}}, out_res};

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> pipe_valid)
    else $error("accepted item did not enter the input register");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    (pipe_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("input register item did not reach the output register");

  a_ready : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!pipe_valid || !m_tvalid || m_tready))
    else $error("input ready does not follow pipeline occupancy");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!pipe_valid && !m_tvalid))
    else $error("pipeline not empty after reset");

endmodule
